// ===== rtl/sorted_priority_queue_assert.svh =====
// Assertion macros for the sorted priority queue RTL.
// Needs a clk and an active-low rst_n in the scope where a macro is used.
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

`ifndef SYNTH
// Checks a property on every clock edge outside reset.
`define SPQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sorted priority queue check failed");
// Checks that a condition never holds outside reset.
`define SPQ_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("sorted priority queue forbidden condition seen");
`else
`define SPQ_ASSERT(lbl, prop)
`define SPQ_NEVER(lbl, cond)
`endif

`endif

// ===== rtl/spq_pkg.sv =====
// Shared types, codes and defaults for the sorted priority queue.
// No dependencies; used by the cell and by the top level.
package spq_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int VALUE_W        = 32;
  localparam int POS_W          = 4;
  localparam int ENTRY_COUNT_W  = 5;

  // Request kinds.
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_FIND   = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]                req_type;
    logic signed [VALUE_W-1:0] item_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]                status;
    logic [POS_W-1:0]          position;
    logic signed [VALUE_W-1:0] head_value;
    logic                      head_valid;
    logic [ENTRY_COUNT_W-1:0]  entry_count;
  } out_item_t;

  // Command broadcast from the control logic to every cell.
  typedef struct packed {
    logic                      ins;
    logic                      rem;
    logic signed [VALUE_W-1:0] value;
  } cell_cmd_t;

  // What a cell shows its neighbors.
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      valid;
    logic                      gt;
    logic                      eq;
  } cell_link_t;

endpackage

// ===== rtl/spq_stream_if.sv =====
// Valid/ready stream channel used for requests and results.
// Payload type is a parameter; depends on nothing else.
interface spq_stream_if #(
  parameter type payload_t = logic [7:0]
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/spq_cell.sv =====
// One storage cell of the sorted chain: holds one entry and shifts with its neighbors.
// Depends on spq_pkg.
module spq_cell
  import spq_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int OCC_W = 5
) (
  input  logic             clk,
  input  logic [OCC_W-1:0] occ,
  input  cell_cmd_t        cmd,
  input  cell_link_t       left,
  input  cell_link_t       right,
  output cell_link_t       link,
  output logic             ins_mark,
  output logic             hit_mark
);

  logic signed [VALUE_W-1:0] value_r;
  logic signed [VALUE_W-1:0] value_nxt;
  logic                      valid;
  logic                      gt;
  logic                      eq;

  assign valid = occ > OCC_W'(IDX);
  assign gt    = valid && (value_r > cmd.value);
  assign eq    = valid && (value_r == cmd.value);

  assign link = '{value: value_r, valid: valid, gt: gt, eq: eq};

  // The insert slot is the first cell not greater than the new value; the
  // hit is the first cell of the run of equal values.
  assign ins_mark = !gt && left.gt;
  assign hit_mark = eq && !left.eq;

  always_comb begin
    value_nxt = value_r;
    if (cmd.ins) begin
      if (!gt) begin
        value_nxt = left.gt ? cmd.value : left.value;
      end
    end else if (cmd.rem) begin
      if (!gt) begin
        value_nxt = right.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

// ===== rtl/sorted_priority_queue.sv =====
// Sorted priority queue, greatest value first: a chain of CAPACITY cells with
// a request and a result stream. One request is taken per clock, back to back,
// and its result appears in the output register on the next cycle; the rate
// is set by the compare-and-shift that every cell performs in parallel, for
// every kind of request alike. A new request is taken whenever the output
// register is empty or its beat is being taken in the same cycle. No clearing
// pass is needed after reset: cells beyond the element count are treated as
// empty. Depends on spq_pkg, spq_stream_if, spq_cell.
`include "sorted_priority_queue_assert.svh"

module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  spq_stream_if.sink   in_ch,
  spq_stream_if.source out_ch
);

  localparam int OCC_W = $clog2(CAPACITY + 1);

  // Element count; the entries themselves live in the cells.
  logic [OCC_W-1:0] occ_r;
  logic [OCC_W-1:0] occ_nxt;

  // Output register. Head and count are read straight from the state: the
  // state only changes when a new request is taken, which is also the edge
  // at which the pending result beat leaves.
  logic             out_valid_r;
  logic [1:0]       status_r;
  logic [1:0]       status_nxt;
  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] pos_nxt;

  logic       accept;
  logic       full;
  logic       found;
  cell_cmd_t  cmd;

  cell_link_t            links [CAPACITY];
  cell_link_t            head_edge;
  cell_link_t            tail_edge;
  logic [CAPACITY-1:0]   ins_mark;
  logic [CAPACITY-1:0]   hit_mark;
  logic [POS_W-1:0]      ins_pos;
  logic [POS_W-1:0]      hit_pos;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign full        = occ_r == OCC_W'(CAPACITY);
  assign found       = |hit_mark;

  // Only a request that actually changes the state moves the chain.
  assign cmd.value = in_ch.payload.item_value;
  assign cmd.ins   = accept && (in_ch.payload.req_type == REQ_INSERT) && !full;
  assign cmd.rem   = accept && (in_ch.payload.req_type == REQ_REMOVE) && found;

  // In front of the head everything counts as greater and nothing as equal,
  // so the head cell is the insert slot when no stored entry is greater.
  assign head_edge = '{value: '0, valid: 1'b1, gt: 1'b1, eq: 1'b0};
  assign tail_edge = '{value: '0, valid: 1'b0, gt: 1'b0, eq: 1'b0};

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    spq_cell #(
      .IDX   (i),
      .OCC_W (OCC_W)
    ) u_cell (
      .clk      (clk),
      .occ      (occ_r),
      .cmd      (cmd),
      .left     ((i == 0) ? head_edge : links[(i == 0) ? 0 : i - 1]),
      .right    ((i == CAPACITY - 1) ? tail_edge : links[(i == CAPACITY - 1) ? i : i + 1]),
      .link     (links[i]),
      .ins_mark (ins_mark[i]),
      .hit_mark (hit_mark[i])
    );
  end

  // At most one cell holds each mark (the entries are sorted), so the position is an OR
  // of the marked cell indexes, wrapped to the width of the position field.
  always_comb begin
    ins_pos = '0;
    hit_pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (ins_mark[i]) begin
        ins_pos = ins_pos | POS_W'(i);
      end
      if (hit_mark[i]) begin
        hit_pos = hit_pos | POS_W'(i);
      end
    end
  end

  always_comb begin
    status_nxt = ST_MISS;
    pos_nxt    = '0;
    occ_nxt    = occ_r;
    unique case (in_ch.payload.req_type)
      REQ_INSERT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          status_nxt = ST_DONE;
          pos_nxt    = ins_pos;
          occ_nxt    = occ_r + OCC_W'(1);
        end
      end
      REQ_REMOVE: begin
        if (found) begin
          status_nxt = ST_DONE;
          pos_nxt    = hit_pos;
          occ_nxt    = occ_r - OCC_W'(1);
        end
      end
      REQ_FIND: begin
        if (found) begin
          status_nxt = ST_DONE;
          pos_nxt    = hit_pos;
        end
      end
      default: begin
        // Unused request kind: no change, reported as not found.
        status_nxt = ST_MISS;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        occ_r       <= occ_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      pos_r    <= pos_nxt;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = '{
    status:      status_r,
    position:    pos_r,
    head_value:  (occ_r != '0) ? links[0].value : '0,
    head_valid:  occ_r != '0,
    entry_count: ENTRY_COUNT_W'(occ_r)
  };

  // The count never passes the number of cells.
  `SPQ_NEVER(a_occ_bound, occ_r > OCC_W'(CAPACITY))
  // Sorted order keeps both slot searches down to at most one marked cell.
  `SPQ_ASSERT(a_ins_onehot, $onehot0(ins_mark))
  `SPQ_ASSERT(a_hit_onehot, $onehot0(hit_mark))
  // The head is never below its successor.
  `SPQ_NEVER(a_head_order, links[1].valid && (links[0].value < links[1].value))
  // A successful insert grows the count by exactly one.
  `SPQ_ASSERT(a_ins_count, cmd.ins |=> (occ_r == $past(occ_r) + OCC_W'(1)))

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the sorted priority queue (greatest value first).
// Depends on spq_pkg, spq_stream_if and sorted_priority_queue from the RTL, with
// the cell and the assertion header beneath it; it reads no files and needs nothing else.
`timescale 1ns / 100ps

module tb;
  import spq_pkg::*;

  localparam int QUEUE_DEPTH = CAPACITY_DEF;

  // Request type 3 is not defined by the block. It must leave the state alone
  // and answer "not found".
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;

  localparam int RANDOM_REQUESTS = 500;

  // Random phases push the queue toward full, toward empty, or hold it
  // somewhere in between.
  typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_t;

  logic clk = 1'b0;
  logic rst_n;

  spq_stream_if #(.payload_t(in_item_t))  req_ch ();
  spq_stream_if #(.payload_t(out_item_t)) res_ch ();

  sorted_priority_queue #(
    .CAPACITY(QUEUE_DEPTH)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (res_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The stimulus is built up front. The driver pulls from pending_requests,
  // and every accepted request is run through the queue shadow. Its answer
  // is stored in expected_answers until the matching result beat comes back.
  in_item_t  pending_requests [$];
  out_item_t expected_answers [$];

  // Shadow of the queue contents. It is kept sorted from greatest to least,
  // with index 0 as the head, exactly as the block must keep its own cells.
  logic signed [VALUE_W-1:0] shadow_entries [QUEUE_DEPTH];
  int                        shadow_count = 0;

  int errors        = 0;
  int requests_sent = 0;
  int results_seen  = 0;
  int done_count    = 0;
  int miss_count    = 0;
  int full_count    = 0;
  int peak_count    = 0;

  // Idle control on both sides. The "calm" counters open stretches where a
  // side never pauses, so back-to-back beats are exercised as well.
  int send_gap;
  int send_calm = 0;
  int recv_stall;
  int recv_calm = 0;

  // Values inserted during generation. Removes and finds draw from this list
  // so that drain phases really empty the queue.
  logic signed [VALUE_W-1:0] issued_values [$];

  // Works out the answer to one request and updates the shadow contents.
  // An insert goes in front of every stored copy of the same value, so its
  // position is the number of entries strictly greater than it. Remove and
  // find both act on the first stored copy, counted from the head.
  function automatic out_item_t predict_answer(in_item_t req);
    out_item_t ans;
    int        slot;
    int        idx;
    ans.status   = ST_MISS;
    ans.position = '0;
    slot         = 0;
    case (req.req_type)
      REQ_INSERT: begin
        if (shadow_count >= QUEUE_DEPTH) begin
          ans.status = ST_FULL;
        end else begin
          while (slot < shadow_count &&
                 $signed(shadow_entries[slot]) > $signed(req.item_value))
            slot++;
          for (idx = shadow_count; idx > slot; idx--)
            shadow_entries[idx] = shadow_entries[idx-1];
          shadow_entries[slot] = req.item_value;
          shadow_count++;
          ans.status   = ST_DONE;
          ans.position = slot[POS_W-1:0];
        end
      end
      REQ_REMOVE, REQ_FIND: begin
        while (slot < shadow_count && shadow_entries[slot] != req.item_value)
          slot++;
        if (slot < shadow_count) begin
          if (req.req_type == REQ_REMOVE) begin
            for (idx = slot; idx + 1 < shadow_count; idx++)
              shadow_entries[idx] = shadow_entries[idx+1];
            shadow_count--;
          end
          ans.status   = ST_DONE;
          ans.position = slot[POS_W-1:0];
        end
      end
      default: begin
        // The unused request type changes nothing.
      end
    endcase
    ans.head_valid  = (shadow_count > 0);
    ans.head_value  = (shadow_count > 0) ? shadow_entries[0] : '0;
    ans.entry_count = shadow_count[ENTRY_COUNT_W-1:0];
    if (shadow_count > peak_count)
      peak_count = shadow_count;
    return ans;
  endfunction

  // Wait, in cycles, before the next beat on one side. Now and then this
  // opens a calm stretch of zero waits.
  function automatic int draw_wait(ref int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 4);
  endfunction

  // Random values mostly come from a small pool near zero, so that
  // duplicates and matches are common. The rest are extremes, their
  // neighbors, or any 32-bit pattern.
  function automatic logic signed [VALUE_W-1:0] draw_value();
    case ($urandom_range(0, 7))
      0, 1: return $urandom;
      2: begin
        case ($urandom_range(0, 3))
          0: return VAL_MAX;
          1: return VAL_MIN;
          2: return VAL_MAX - 1;
          default: return VAL_MIN + 1;
        endcase
      end
      default: return $signed($urandom_range(0, 8)) - 4;
    endcase
  endfunction

  task automatic add_request(logic [1:0] kind, logic signed [VALUE_W-1:0] value);
    in_item_t req;
    req.req_type   = kind;
    req.item_value = value;
    pending_requests.push_back(req);
    if (kind == REQ_INSERT)
      issued_values.push_back(value);
  endtask

  // Picks the value for a remove or a find. Most of the time it is a value
  // that was inserted earlier. A remove also takes that value off the list.
  function automatic logic signed [VALUE_W-1:0] pick_target(logic [1:0] kind);
    int                        pick;
    logic signed [VALUE_W-1:0] value;
    if (issued_values.size() == 0 || $urandom_range(0, 9) < 3)
      return draw_value();
    pick  = $urandom_range(0, issued_values.size() - 1);
    value = issued_values[pick];
    if (kind == REQ_REMOVE)
      issued_values.delete(pick);
    return value;
  endfunction

  task automatic compare_field(string field, logic signed [63:0] want,
                               logic signed [63:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  // Request driver. A beat stays on the channel until it is taken. After it
  // is taken, the driver waits the drawn number of cycles before it offers
  // the next one. Each signal gets at most one nonblocking write per edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      req_ch.valid   <= 1'b0;
      req_ch.payload <= '0;
      send_gap = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        expected_answers.push_back(predict_answer(req_ch.payload));
        requests_sent++;
      end
      if (!(req_ch.valid && !req_ch.ready)) begin
        if (send_gap > 0 || pending_requests.size() == 0) begin
          if (send_gap > 0)
            send_gap--;
          req_ch.valid <= 1'b0;
        end else begin
          req_ch.valid   <= 1'b1;
          req_ch.payload <= pending_requests.pop_front();
          send_gap = draw_wait(send_calm);
        end
      end
    end
  end

  // Result monitor. Every result beat is checked field by field against
  // the oldest answer still waiting. After each beat, ready is held low for
  // a drawn number of cycles, so the block's output register has to hold
  // its beat and stall its input side.
  always @(posedge clk) begin
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        results_seen++;
        if (expected_answers.size() == 0) begin
          errors++;
          $display("%0t: result beat with no request waiting, expected none, actual %p",
                   $time, res_ch.payload);
        end else begin
          out_item_t want;
          want = expected_answers.pop_front();
          compare_field("status", 64'(want.status), 64'(res_ch.payload.status));
          compare_field("position", 64'(want.position), 64'(res_ch.payload.position));
          compare_field("head_value", 64'(want.head_value),
                        64'(res_ch.payload.head_value));
          compare_field("head_valid", 64'(want.head_valid),
                        64'(res_ch.payload.head_valid));
          compare_field("entry_count", 64'(want.entry_count),
                        64'(res_ch.payload.entry_count));
          case (want.status)
            ST_DONE: done_count++;
            ST_FULL: full_count++;
            default: miss_count++;
          endcase
        end
        recv_stall = draw_wait(recv_calm);
      end
      if (recv_stall > 0) begin
        recv_stall--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    phase_t phase;
    int     phase_len;
    int     left;
    int     roll;
    int     fill_idx;
    logic [1:0] kind;

    rst_n = 1'b0;

    // Directed part. It starts with lookups on an empty queue, where the
    // head must read as invalid and zero. Then come both extremes, a
    // duplicate that must go in front of its twin, hits and misses for
    // remove and find, the unused request type and removal of the head.
    // Last, the queue is filled to capacity, a further insert must be
    // rejected as full, and the least value is found in the last slot.
    add_request(REQ_FIND, 32'sd0);
    add_request(REQ_REMOVE, 32'sd5);
    add_request(REQ_INSERT, VAL_MAX);
    add_request(REQ_INSERT, VAL_MIN);
    add_request(REQ_INSERT, 32'sd0);
    add_request(REQ_INSERT, -32'sd1);
    add_request(REQ_INSERT, 32'sd0);
    add_request(REQ_FIND, 32'sd0);
    add_request(REQ_FIND, VAL_MIN);
    add_request(REQ_FIND, 32'sd42);
    add_request(REQ_REMOVE, 32'sd0);
    add_request(REQ_REMOVE, 32'sd42);
    add_request(REQ_UNUSED, -32'sd1);
    add_request(REQ_REMOVE, VAL_MAX);
    for (fill_idx = 1; fill_idx <= QUEUE_DEPTH - 3; fill_idx++)
      add_request(REQ_INSERT, (fill_idx % 2 == 1) ? fill_idx * 32'sd1000003
                                                  : -fill_idx * 32'sd77);
    add_request(REQ_INSERT, VAL_MAX);
    add_request(REQ_FIND, VAL_MIN);
    issued_values.delete();

    // Random part. It runs in phases that lean toward inserts or toward
    // removes, so the queue swings between full and empty many times.
    // Finds and the unused type are mixed in throughout.
    left = RANDOM_REQUESTS;
    while (left > 0) begin
      phase_len = $urandom_range(20, 60);
      case ($urandom_range(0, 2))
        0: phase = PH_FILL;
        1: phase = PH_DRAIN;
        default: phase = PH_MIXED;
      endcase
      for (int n = 0; n < phase_len && left > 0; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 3)
          kind = REQ_UNUSED;
        else if (phase == PH_FILL)
          kind = (roll < 70) ? REQ_INSERT : (roll < 85) ? REQ_FIND : REQ_REMOVE;
        else if (phase == PH_DRAIN)
          kind = (roll < 20) ? REQ_INSERT : (roll < 75) ? REQ_REMOVE : REQ_FIND;
        else
          kind = (roll < 40) ? REQ_INSERT : (roll < 70) ? REQ_REMOVE : REQ_FIND;
        if (kind == REQ_INSERT || kind == REQ_UNUSED)
          add_request(kind, draw_value());
        else
          add_request(kind, pick_target(kind));
        left--;
      end
    end

    // Reset is synchronous and is held low before the run starts.
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Wait until every request has gone in and every answer has come back.
    // The run then waits on before it ends, so that a stray extra result beat can show up.
    while (pending_requests.size() != 0 || req_ch.valid)
      @(posedge clk);
    while (expected_answers.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Run covered %0d requests and %0d results: %0d done, %0d not found, %0d full.",
             requests_sent, results_seen, done_count, miss_count, full_count);
    $display("Peak occupancy %0d of %0d entries; %0d field mismatches.",
             peak_count, QUEUE_DEPTH, errors);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog. The slowest correct run for about 530 requests takes under 60 us,
  // so this limit leaves a wide margin.
  initial begin
    #1ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/spq_pkg.sv
rtl/spq_stream_if.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
tb/tb.sv
